// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared property shorthands for the rtl checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/mrga_pkg.sv =====
// ----------------------------------------------------------------------------
// mrga_pkg
// shared types and codes of the grant allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mrga_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RES_USE  = 1'd1;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_UNKNOWN_RES   = 3'd1;
    localparam logic [2:0] ST_INSUFFICIENT  = 3'd2;
    localparam logic [2:0] ST_UNKNOWN_GRANT = 3'd3;
    localparam logic [2:0] ST_TABLE_FULL    = 3'd4;
    localparam logic [2:0] ST_TOO_LONG      = 3'd5;

    typedef struct packed {
        logic [2:0] idx;
        logic [7:0] qty;
    } t_item;

endpackage

// ===== rtl/core/multi_resource_grant_allocator.sv =====
// Multi-resource all-or-nothing grant allocator. Keeps an 8-bit available count per
// resource (loaded by writing the capacity register) and a grant table held in two
// single-port memories: a tag memory (grant id and length per slot) and an element
// memory. A request element without the last mark is stored and the block stays idle. A
// last element runs the sufficiency check over the elements, the free-slot scan (up to
// GRANT_SLOTS slots), the commit of each element, the tag write and the hand-over of the
// result (held while the output register is full), and only then is the next beat taken.
// A release reads the tag memory slot by slot until the id matches (up to GRANT_SLOTS
// slots), then reads each stored element and adds it back. Results sit in an output
// register, so a new beat is taken while a result waits. No clearing pass after reset.
// ----------------------------------------------------------------------------
// multi_resource_grant_allocator
// counting resource allocator with all-or-nothing grants and release
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multi_resource_grant_allocator #(
    parameter int NUM_RESOURCES     = 8,
    parameter int MAX_REQUEST_ITEMS = 8,
    parameter int GRANT_SLOTS       = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mrga_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mrga_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // resource_index, quantity, release_id
    input  logic [mrga_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // operation
    input  logic                               s_axis_tuser,
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // status, granted_id
    output logic [mrga_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // was_release
    output logic                               m_axis_tuser
);
    import mrga_pkg::*;

    localparam int RW = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int IW = (MAX_REQUEST_ITEMS > 1) ? $clog2(MAX_REQUEST_ITEMS) : 1;
    localparam int LW = $clog2(MAX_REQUEST_ITEMS + 1);
    localparam int SW = $clog2(GRANT_SLOTS);
    localparam int TW = 16 + LW;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_FIND, S_COMMIT, S_TAG_WR,
        S_SCAN_RD, S_SCAN_CMP, S_REL_RD, S_REL_ADD, S_EMIT
    } t_state;

    t_state        r_state;
    logic [7:0]    r_avail [NUM_RESOURCES];
    t_item         r_pend [MAX_REQUEST_ITEMS];
    logic [LW-1:0] r_pend_len;
    logic [2:0]    r_pend_err;
    logic [15:0]   r_next_id;
    logic          r_valid [GRANT_SLOTS];
    logic [3:0]    r_res_use;
    logic [LW-1:0] r_cnt;
    logic [SW-1:0] r_slot;
    logic [15:0]   r_rel_id;
    logic [LW-1:0] r_rel_len;
    logic [2:0]    r_res_status;
    logic [15:0]   r_res_id;
    logic          r_res_rel;
    logic          r_out_valid;
    logic [2:0]    r_out_status;
    logic [15:0]   r_out_id;
    logic          r_out_rel;

    logic [TW-1:0] tag_mem [GRANT_SLOTS];
    logic [TW-1:0] r_tag_rd;
    logic [10:0]   item_mem [GRANT_SLOTS << IW];
    logic [10:0]   r_item_rd;

    logic          in_op;
    t_item         in_item;
    logic [15:0]   in_rid;
    logic [2:0]    n_pend_err;
    logic          elem_bad;
    t_item         cur_item;
    t_item         rel_item;
    logic [7:0]    cur_avail;
    logic [7:0]    rel_avail;
    logic [8:0]    rel_sum;
    logic [SW+IW-1:0] item_addr;
    logic          item_we;
    logic          tag_we;

    assign in_op       = s_axis_tuser;
    assign in_item.idx = s_axis_tdata[2:0];
    assign in_item.qty = s_axis_tdata[10:3];
    assign in_rid      = s_axis_tdata[26:11];

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_id, r_out_status};
    assign m_axis_tuser  = r_out_rel;

    assign elem_bad  = (4'(in_item.idx) >= r_res_use) || (4'(in_item.idx) >= 4'(NUM_RESOURCES));
    assign cur_item  = r_pend[r_cnt[IW-1:0]];
    assign cur_avail = r_avail[cur_item.idx[RW-1:0]];
    assign rel_item  = t_item'(r_item_rd);
    assign rel_avail = r_avail[rel_item.idx[RW-1:0]];
    assign rel_sum   = {1'b0, rel_avail} + {1'b0, rel_item.qty};
    assign item_addr = {r_slot, r_cnt[IW-1:0]};
    assign item_we   = (r_state == S_COMMIT) && (r_cnt != r_pend_len);
    assign tag_we    = (r_state == S_TAG_WR);

    always_comb begin
        n_pend_err = r_pend_err;
        if (r_pend_len >= LW'(MAX_REQUEST_ITEMS)) begin
            if (r_pend_err == ST_OK) n_pend_err = ST_TOO_LONG;
        end else if (elem_bad && r_pend_err == ST_OK) begin
            n_pend_err = ST_UNKNOWN_RES;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            tag_mem[r_slot] <= {r_next_id, r_pend_len};
        end
        r_tag_rd <= tag_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (item_we) begin
            item_mem[item_addr] <= cur_item;
        end
        r_item_rd <= item_mem[item_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pend_len  <= '0;
            r_pend_err  <= ST_OK;
            r_next_id   <= '0;
            r_res_use   <= 4'd8;
            r_cnt       <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_RESOURCES; i++) r_avail[i] <= '0;
            for (int i = 0; i < GRANT_SLOTS; i++) r_valid[i] <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready && r_state != S_EMIT) r_out_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_CAPACITY: begin
                        for (int i = 0; i < NUM_RESOURCES; i++)
                            r_avail[i] <= i_cfg_data[8*i +: 8];
                    end
                    REG_RES_USE: r_res_use <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        if (in_op == OP_RELEASE) begin
                            r_rel_id <= in_rid;
                            r_slot   <= '0;
                            r_state  <= S_SCAN_RD;
                        end else if (s_axis_tlast && n_pend_err != ST_OK) begin
                            r_res_status <= n_pend_err;
                            r_res_id     <= '0;
                            r_res_rel    <= 1'b0;
                            r_pend_len   <= '0;
                            r_pend_err   <= ST_OK;
                            r_state      <= S_EMIT;
                        end else begin
                            if (r_pend_len < LW'(MAX_REQUEST_ITEMS)) begin
                                r_pend[r_pend_len[IW-1:0]] <= in_item;
                                r_pend_len <= r_pend_len + 1'b1;
                            end
                            r_pend_err <= n_pend_err;
                            if (s_axis_tlast) begin
                                r_cnt   <= '0;
                                r_state <= S_CHECK;
                            end
                        end
                    end
                end
                S_CHECK: begin
                    if (r_cnt == r_pend_len) begin
                        r_slot  <= '0;
                        r_state <= S_FIND;
                    end else if (cur_avail < cur_item.qty) begin
                        r_res_status <= ST_INSUFFICIENT;
                        r_res_id     <= '0;
                        r_res_rel    <= 1'b0;
                        r_pend_len   <= '0;
                        r_state      <= S_EMIT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_FIND: begin
                    if (!r_valid[r_slot]) begin
                        r_cnt   <= '0;
                        r_state <= S_COMMIT;
                    end else if (r_slot == SW'(GRANT_SLOTS - 1)) begin
                        r_res_status <= ST_TABLE_FULL;
                        r_res_id     <= '0;
                        r_res_rel    <= 1'b0;
                        r_pend_len   <= '0;
                        r_state      <= S_EMIT;
                    end else begin
                        r_slot <= r_slot + 1'b1;
                    end
                end
                S_COMMIT: begin
                    if (r_cnt == r_pend_len) begin
                        r_state <= S_TAG_WR;
                    end else begin
                        r_avail[cur_item.idx[RW-1:0]] <=
                            (cur_avail > cur_item.qty) ? cur_avail - cur_item.qty : 8'd0;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_TAG_WR: begin
                    r_valid[r_slot] <= 1'b1;
                    r_res_status    <= ST_OK;
                    r_res_id        <= r_next_id;
                    r_res_rel       <= 1'b0;
                    r_next_id       <= r_next_id + 1'b1;
                    r_pend_len      <= '0;
                    r_state         <= S_EMIT;
                end
                S_SCAN_RD: r_state <= S_SCAN_CMP;
                S_SCAN_CMP: begin
                    if (r_valid[r_slot] && r_tag_rd[TW-1:LW] == r_rel_id) begin
                        r_rel_len <= r_tag_rd[LW-1:0];
                        r_cnt     <= '0;
                        r_state   <= S_REL_RD;
                    end else if (r_slot == SW'(GRANT_SLOTS - 1)) begin
                        r_res_status <= ST_UNKNOWN_GRANT;
                        r_res_id     <= r_rel_id;
                        r_res_rel    <= 1'b1;
                        r_state      <= S_EMIT;
                    end else begin
                        r_slot  <= r_slot + 1'b1;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_REL_RD: begin
                    if (r_cnt == r_rel_len) begin
                        r_valid[r_slot] <= 1'b0;
                        r_res_status    <= ST_OK;
                        r_res_id        <= r_rel_id;
                        r_res_rel       <= 1'b1;
                        r_state         <= S_EMIT;
                    end else begin
                        r_state <= S_REL_ADD;
                    end
                end
                S_REL_ADD: begin
                    r_avail[rel_item.idx[RW-1:0]] <= rel_sum[8] ? 8'hFF : rel_sum[7:0];
                    r_cnt   <= r_cnt + 1'b1;
                    r_state <= S_REL_RD;
                end
                S_EMIT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_id     <= r_res_id;
                        r_out_rel    <= r_res_rel;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPLY(a_pend_len_max, i_clk, i_rst_n, 1'b1, r_pend_len <= LW'(MAX_REQUEST_ITEMS))
    `ASSERT_NEXT(a_grant_sets_valid, i_clk, i_rst_n, r_state == S_TAG_WR, r_valid[$past(r_slot)])
    `ASSERT_NEXT(a_id_only_on_grant, i_clk, i_rst_n, r_state != S_TAG_WR, r_next_id == $past(r_next_id))

endmodule
